// File: sv/indexed_min_heap_queue_macros.svh
// Assertion macros for the indexed min-heap queue.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define IHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heap queue assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define IHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heap queue assertion failed");
`else
`define IHQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define IHQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/ihq_pkg.sv
// Shared codes and types for the indexed min-heap queue.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none
package ihq_pkg;

    // Operation codes carried by an input item.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_EXTRACT = 2'd1;
    localparam logic [1:0] MODE_DECR    = 2'd2;
    localparam logic [1:0] MODE_QUERY   = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_ABSENT = 3'd3;
    localparam logic [2:0] ST_DUP    = 3'd4;

    // Datapath commands issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_READ_KEY  = 4'd2;
    localparam logic [3:0] OP_KEY_CAP   = 4'd3;
    localparam logic [3:0] OP_LOAD_BEG  = 4'd4;
    localparam logic [3:0] OP_EXT_BEG   = 4'd5;
    localparam logic [3:0] OP_DEC_BEG   = 4'd6;
    localparam logic [3:0] OP_UP_READ   = 4'd7;
    localparam logic [3:0] OP_UP_STEP   = 4'd8;
    localparam logic [3:0] OP_DN_READ   = 4'd9;
    localparam logic [3:0] OP_DN_STEP   = 4'd10;
    localparam logic [3:0] OP_FINISH    = 4'd11;
    localparam logic [3:0] OP_RESULT    = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [2:0] status;
    } ihq_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       held;
        logic       empty;
        logic       full;
        logic       one_left;
        logic       idx_zero;
        logic       has_child;
        logic       up_move;
        logic       dn_move;
    } ihq_stat_t;

endpackage
`default_nettype wire

// File: sv/ihq_datapath.sv
// Datapath of the indexed min-heap queue: heap and position memories, sift registers.
// Depends on ihq_pkg; driven by ihq_ctrl through command and status structs.
`default_nettype none
module ihq_datapath import ihq_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire ihq_cmd_t           cmd,
    output ihq_stat_t               stat,
    input  wire logic [1:0]         in_mode,
    input  wire logic [7:0]         in_vertex,
    input  wire logic signed [31:0] in_key,
    output logic [7:0]              out_vertex,
    output logic signed [31:0]      out_key,
    output logic                    out_in_heap,
    output logic [2:0]              out_status,
    output logic [8:0]              out_count
);

    localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SZ_BITS  = $clog2(CAPACITY + 1);

    // Heap slots and the vertex-to-slot map.
    logic [7:0]                 heap_v_mem [CAPACITY];
    logic signed [KEY_BITS-1:0] heap_k_mem [CAPACITY];
    logic [IDX_BITS-1:0]        pos_mem [256];

    logic [255:0]               valid_reg;
    logic [SZ_BITS-1:0]         size_reg;
    logic [IDX_BITS-1:0]        idx_reg;
    logic [7:0]                 cur_v_reg;
    logic signed [KEY_BITS-1:0] cur_k_reg;
    logic [1:0]                 mode_reg;
    logic [7:0]                 vert_reg;
    logic signed [KEY_BITS-1:0] key_reg;
    logic                       held_reg;
    logic                       l_ok_reg;
    logic                       r_ok_reg;
    logic [7:0]                 rd_a_v_reg;
    logic signed [KEY_BITS-1:0] rd_a_k_reg;
    logic [7:0]                 rd_b_v_reg;
    logic signed [KEY_BITS-1:0] rd_b_k_reg;
    logic [IDX_BITS-1:0]        pos_rd_reg;
    logic [7:0]                 res_v_reg;
    logic signed [31:0]         res_k_reg;
    logic                       res_held_reg;

    logic [IDX_BITS-1:0]        addr_a;
    logic [IDX_BITS-1:0]        addr_b;
    logic [7:0]                 pos_ra;
    logic                       heap_we;
    logic [IDX_BITS-1:0]        heap_wa;
    logic [7:0]                 heap_wv;
    logic signed [KEY_BITS-1:0] heap_wk;
    logic                       pos_we;
    logic [7:0]                 pos_wa;
    logic [IDX_BITS-1:0]        pos_wd;

    logic [IDX_BITS-1:0]        parent;
    logic [SZ_BITS:0]           l_wide;
    logic [SZ_BITS:0]           r_wide;
    logic signed [KEY_BITS-1:0] key_in_w;
    logic signed [KEY_BITS-1:0] small_k;
    logic                       sel_l;
    logic                       sel_r;

    // Index arithmetic and key wrapping.
    assign parent   = (idx_reg - IDX_BITS'(1)) >> 1;
    assign l_wide   = (SZ_BITS + 1)'({idx_reg, 1'b1});
    assign r_wide   = l_wide + (SZ_BITS + 1)'(1);
    assign key_in_w = KEY_BITS'(64'(in_key));

    // Sift-down child choice; the left child wins a tie.
    assign sel_l   = l_ok_reg && (rd_a_k_reg < cur_k_reg);
    assign small_k = sel_l ? rd_a_k_reg : cur_k_reg;
    assign sel_r   = r_ok_reg && (rd_b_k_reg < small_k);

    // Status toward the controller.
    always_comb begin
        stat.mode      = mode_reg;
        stat.held      = held_reg;
        stat.empty     = (size_reg == '0);
        stat.full      = (size_reg >= SZ_BITS'(CAPACITY));
        stat.one_left  = (size_reg == SZ_BITS'(1));
        stat.idx_zero  = (idx_reg == '0);
        stat.has_child = (l_wide < {1'b0, size_reg});
        stat.up_move   = (cur_k_reg < rd_a_k_reg);
        stat.dn_move   = sel_l || sel_r;
    end

    // Read addresses of the heap ports and the position map.
    always_comb begin
        addr_a = '0;
        addr_b = IDX_BITS'(size_reg - SZ_BITS'(1));
        case (cmd.op)
            OP_READ_KEY: addr_a = pos_rd_reg;
            OP_UP_READ:  addr_a = parent;
            OP_DN_READ: begin
                addr_a = l_wide[IDX_BITS-1:0];
                addr_b = r_wide[IDX_BITS-1:0];
            end
            default:     addr_a = '0;
        endcase
        pos_ra = (cmd.op == OP_ACCEPT) ? in_vertex : vert_reg;
    end

    // Write ports: a step moves one entry into the hole, finish drops the carried entry.
    always_comb begin
        heap_we = 1'b0;
        heap_wa = idx_reg;
        heap_wv = cur_v_reg;
        heap_wk = cur_k_reg;
        pos_we  = 1'b0;
        pos_wa  = cur_v_reg;
        pos_wd  = idx_reg;
        case (cmd.op)
            OP_UP_STEP: begin
                heap_we = 1'b1;
                heap_wv = rd_a_v_reg;
                heap_wk = rd_a_k_reg;
                pos_we  = 1'b1;
                pos_wa  = rd_a_v_reg;
            end
            OP_DN_STEP: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
                if (sel_r) begin
                    heap_wv = rd_b_v_reg;
                    heap_wk = rd_b_k_reg;
                    pos_wa  = rd_b_v_reg;
                end else begin
                    heap_wv = rd_a_v_reg;
                    heap_wk = rd_a_k_reg;
                    pos_wa  = rd_a_v_reg;
                end
            end
            OP_FINISH: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            default: heap_we = 1'b0;
        endcase
    end

    // Memories with registered reads.
    always_ff @(posedge aclk) begin
        if (heap_we) begin
            heap_v_mem[heap_wa] <= heap_wv;
            heap_k_mem[heap_wa] <= heap_wk;
        end
        rd_a_v_reg <= heap_v_mem[addr_a];
        rd_a_k_reg <= heap_k_mem[addr_a];
        rd_b_v_reg <= heap_v_mem[addr_b];
        rd_b_k_reg <= heap_k_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (pos_we) begin
            pos_mem[pos_wa] <= pos_wd;
        end
        pos_rd_reg <= pos_mem[pos_ra];
    end

    // Control state: membership bits and entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            size_reg  <= '0;
        end else begin
            case (cmd.op)
                OP_LOAD_BEG: begin
                    valid_reg[vert_reg] <= 1'b1;
                    size_reg            <= size_reg + SZ_BITS'(1);
                end
                OP_EXT_BEG: begin
                    valid_reg[rd_a_v_reg] <= 1'b0;
                    size_reg              <= size_reg - SZ_BITS'(1);
                end
                default: size_reg <= size_reg;
            endcase
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_ACCEPT: begin
                mode_reg     <= in_mode;
                vert_reg     <= in_vertex;
                key_reg      <= key_in_w;
                held_reg     <= valid_reg[in_vertex];
                res_v_reg    <= in_vertex;
                res_k_reg    <= '0;
                res_held_reg <= 1'b0;
            end
            OP_KEY_CAP: begin
                res_k_reg    <= 32'(64'(rd_a_k_reg));
                res_held_reg <= 1'b1;
            end
            OP_LOAD_BEG: begin
                cur_v_reg    <= vert_reg;
                cur_k_reg    <= key_reg;
                idx_reg      <= IDX_BITS'(size_reg);
                res_k_reg    <= 32'(64'(key_reg));
                res_held_reg <= 1'b1;
            end
            OP_DEC_BEG: begin
                cur_v_reg    <= vert_reg;
                cur_k_reg    <= key_reg;
                idx_reg      <= pos_rd_reg;
                res_k_reg    <= 32'(64'(key_reg));
                res_held_reg <= 1'b1;
            end
            OP_EXT_BEG: begin
                cur_v_reg    <= rd_b_v_reg;
                cur_k_reg    <= rd_b_k_reg;
                idx_reg      <= '0;
                res_v_reg    <= rd_a_v_reg;
                res_k_reg    <= 32'(64'(rd_a_k_reg));
                res_held_reg <= 1'b0;
            end
            OP_UP_STEP: idx_reg <= parent;
            OP_DN_READ: begin
                l_ok_reg <= (l_wide < {1'b0, size_reg});
                r_ok_reg <= (r_wide < {1'b0, size_reg});
            end
            OP_DN_STEP: idx_reg <= sel_r ? r_wide[IDX_BITS-1:0] : l_wide[IDX_BITS-1:0];
            default: idx_reg <= idx_reg;
        endcase
    end

    // Result register toward the output channel.
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_RESULT) begin
            out_vertex  <= res_v_reg;
            out_key     <= res_k_reg;
            out_in_heap <= res_held_reg;
            out_status  <= cmd.status;
            out_count   <= 9'(size_reg);
        end
    end

endmodule
`default_nettype wire

// File: sv/ihq_ctrl.sv
// Controller state machine of the indexed min-heap queue.
// Depends on ihq_pkg and the assertion macros; commands ihq_datapath.
`default_nettype none
`include "indexed_min_heap_queue_macros.svh"
module ihq_ctrl import ihq_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    input  wire ihq_stat_t stat,
    output ihq_cmd_t       cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_KEYCAP  = 4'd2;
    localparam logic [3:0] S_UP_READ = 4'd3;
    localparam logic [3:0] S_UP_CMP  = 4'd4;
    localparam logic [3:0] S_DN_READ = 4'd5;
    localparam logic [3:0] S_DN_CMP  = 4'd6;
    localparam logic [3:0] S_RESULT  = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [2:0] status_reg;
    logic [2:0] status_next;
    logic       m_tvalid_reg;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Next state and the command of this cycle.
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd.op      = OP_NONE;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                status_next = ST_OK;
                state_next  = S_RESULT;
                case (stat.mode)
                    MODE_LOAD: begin
                        if (stat.held) begin
                            status_next = ST_DUP;
                            cmd.op      = OP_READ_KEY;
                            state_next  = S_KEYCAP;
                        end else if (stat.full) begin
                            status_next = ST_FULL;
                        end else begin
                            cmd.op     = OP_LOAD_BEG;
                            state_next = S_UP_READ;
                        end
                    end
                    MODE_EXTRACT: begin
                        if (stat.empty) begin
                            status_next = ST_EMPTY;
                        end else begin
                            cmd.op = OP_EXT_BEG;
                            if (!stat.one_left) begin
                                state_next = S_DN_READ;
                            end
                        end
                    end
                    MODE_DECR: begin
                        if (!stat.held) begin
                            status_next = ST_ABSENT;
                        end else begin
                            cmd.op     = OP_DEC_BEG;
                            state_next = S_UP_READ;
                        end
                    end
                    default: begin
                        if (stat.held) begin
                            cmd.op     = OP_READ_KEY;
                            state_next = S_KEYCAP;
                        end
                    end
                endcase
            end
            S_KEYCAP: begin
                cmd.op     = OP_KEY_CAP;
                state_next = S_RESULT;
            end
            S_UP_READ: begin
                if (stat.idx_zero) begin
                    cmd.op     = OP_FINISH;
                    state_next = S_RESULT;
                end else begin
                    cmd.op     = OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (stat.up_move) begin
                    cmd.op     = OP_UP_STEP;
                    state_next = S_UP_READ;
                end else begin
                    cmd.op     = OP_FINISH;
                    state_next = S_RESULT;
                end
            end
            S_DN_READ: begin
                if (stat.has_child) begin
                    cmd.op     = OP_DN_READ;
                    state_next = S_DN_CMP;
                end else begin
                    cmd.op     = OP_FINISH;
                    state_next = S_RESULT;
                end
            end
            S_DN_CMP: begin
                if (stat.dn_move) begin
                    cmd.op     = OP_DN_STEP;
                    state_next = S_DN_READ;
                end else begin
                    cmd.op     = OP_FINISH;
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State, status and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            status_reg   <= ST_OK;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            if (cmd.op == OP_RESULT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // An accepted item is always decided in the following cycle.
    `IHQ_ASSERT_NEXT(a_accept_decide, aclk, aresetn, s_tvalid && s_tready, state_reg == S_DECIDE)
    // A result waits while the previous one is still held at the output.
    `IHQ_ASSERT_NEXT(a_result_holds, aclk, aresetn, (state_reg == S_RESULT) && !out_free, state_reg == S_RESULT)
    // A new result appears only after the result state.
    `IHQ_ASSERT_IMPL(a_valid_source, aclk, aresetn, $rose(m_tvalid_reg), $past(state_reg) == S_RESULT)

endmodule
`default_nettype wire

// File: sv/indexed_min_heap_queue.sv
// Top level of the indexed min-heap queue: stream ports, controller and datapath.
// Depends on ihq_pkg, ihq_ctrl and ihq_datapath.
//
// Indexed binary min-heap of (vertex, key) entries for up to CAPACITY entries and 256
// vertices. Each input item carries an operation in s_tuser (load, extract minimum,
// decrease key, query) and returns exactly one result item with status in m_tuser.
// One item is processed at a time. The sift loop walks the heap one level per pass,
// each pass being one registered memory read, then compare and move. A new item may
// be accepted while the previous result still waits at the output register.
`default_nettype none
module indexed_min_heap_queue import ihq_pkg::*; #(
    parameter int CAPACITY = 256,
    parameter int KEY_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // vertex_id [7:0], key_value [39:8]
    input  wire logic [1:0]  s_tuser,  // mode [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,  // out_vertex [7:0], out_key [39:8], in_heap [40],
                                       // entry_count [49:41], zero fill [55:50]
    output logic [2:0]       m_tuser   // status [2:0]
);

    ihq_cmd_t           cmd;
    ihq_stat_t          stat;
    logic [7:0]         out_vertex;
    logic signed [31:0] out_key;
    logic               out_in_heap;
    logic [2:0]         out_status;
    logic [8:0]         out_count;

    ihq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ihq_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (s_tuser),
        .in_vertex   (s_tdata[7:0]),
        .in_key      (s_tdata[39:8]),
        .out_vertex  (out_vertex),
        .out_key     (out_key),
        .out_in_heap (out_in_heap),
        .out_status  (out_status),
        .out_count   (out_count)
    );

    // Pack the result item.
    assign m_tdata = {6'd0, out_count, out_in_heap, out_key, out_vertex};
    assign m_tuser = out_status;

endmodule
`default_nettype wire

// File: tb/indexed_min_heap_queue_test.sv
// Self-checking testbench for the indexed min-heap queue: directed table, then random traffic.
// Depends on ihq_pkg and indexed_min_heap_queue; predicts every result with its own heap model.
`timescale 1ns / 100ps
module indexed_min_heap_queue_test;
    import ihq_pkg::*;

    localparam int NUM_SLOTS = 256;
    localparam int NO_SLOT = 256;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] vertex;
        logic [31:0] key;
    } op_item_t;

    typedef struct packed {
        logic [7:0] vertex;
        logic [31:0] key;
        logic held;
        logic [2:0] status;
        logic [8:0] count;
    } heap_result_t;

    // Directed rows: an expected result is given where it is obvious, else the model decides.
    typedef struct {
        op_item_t item;
        bit fixed;
        heap_result_t result;
    } table_row_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [39:0] s_tdata;
    logic [1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [55:0] m_tdata;
    logic [2:0] m_tuser;

    indexed_min_heap_queue uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // Predictor state: heap array, vertex-to-slot map and entry count.
    logic [7:0] pq_vertex [NUM_SLOTS];
    logic signed [31:0] pq_key [NUM_SLOTS];
    int slot_map [256];
    int pq_count;

    heap_result_t expected_results [$];
    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int n_ok = 0, n_empty = 0, n_full = 0, n_absent = 0, n_dup = 0;

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    function automatic bit vertex_held(int v);
        return slot_map[v] < pq_count;
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [7:0] tv;
        logic signed [31:0] tk;
        tv = pq_vertex[a];
        tk = pq_key[a];
        pq_vertex[a] = pq_vertex[b];
        pq_key[a] = pq_key[b];
        pq_vertex[b] = tv;
        pq_key[b] = tk;
        slot_map[pq_vertex[a]] = a;
        slot_map[pq_vertex[b]] = b;
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(pq_key[i] < pq_key[p])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int i);
        int s, l, r;
        forever begin
            s = i;
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (l < pq_count && pq_key[l] < pq_key[s]) s = l;
            if (r < pq_count && pq_key[r] < pq_key[s]) s = r;
            if (s == i) break;
            swap_slots(i, s);
            i = s;
        end
    endfunction

    // Applies one item to the predictor and returns the result it should produce.
    function automatic heap_result_t apply_heap_op(op_item_t it);
        heap_result_t r;
        int v, last;
        v = it.vertex;
        r = '0;
        r.vertex = it.vertex;
        case (it.mode)
            MODE_LOAD: begin
                if (vertex_held(v)) begin
                    r.status = ST_DUP;
                    r.key = pq_key[slot_map[v]];
                    r.held = 1;
                end else if (pq_count >= NUM_SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    pq_vertex[pq_count] = it.vertex;
                    pq_key[pq_count] = it.key;
                    slot_map[v] = pq_count;
                    pq_count++;
                    bubble_up(pq_count - 1);
                    r.key = it.key;
                    r.held = 1;
                end
            end
            MODE_EXTRACT: begin
                if (pq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    last = pq_count - 1;
                    r.vertex = pq_vertex[0];
                    r.key = pq_key[0];
                    if (last > 0) begin
                        pq_vertex[0] = pq_vertex[last];
                        pq_key[0] = pq_key[last];
                        slot_map[pq_vertex[0]] = 0;
                    end
                    pq_count = last;
                    slot_map[r.vertex] = NO_SLOT;
                    bubble_down(0);
                end
            end
            MODE_DECR: begin
                if (!vertex_held(v)) begin
                    r.status = ST_ABSENT;
                end else begin
                    pq_key[slot_map[v]] = it.key;
                    bubble_up(slot_map[v]);
                    r.key = it.key;
                    r.held = 1;
                end
            end
            default: begin
                if (vertex_held(v)) begin
                    r.held = 1;
                    r.key = pq_key[slot_map[v]];
                end
            end
        endcase
        r.count = pq_count[8:0];
        return r;
    endfunction

    // Sends one item, honoring the current sender idle rate. Valid stays high between
    // items sent back to back; it drops only for idle cycles and when draining.
    task automatic send_item(op_item_t it, bit fixed, heap_result_t given);
        heap_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {it.key, it.vertex};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_heap_op(it);
        if (fixed && predicted != given)
            $display("directed row disagrees with predictor at item %0d", items_sent);
        expected_results.push_back(fixed ? given : predicted);
        items_sent++;
    endtask

    function automatic op_item_t make_op(logic [1:0] m, int v, logic [31:0] k);
        op_item_t it;
        it.mode = m;
        it.vertex = v[7:0];
        it.key = k;
        return it;
    endfunction

    function automatic logic [31:0] random_key();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(15);
            3: return $urandom;
            default: return $urandom_range(2000) - 1000;
        endcase
    endfunction

    // Random item biased toward held vertices so decreases and queries find them often.
    function automatic op_item_t random_op(int load_bias);
        int v, sel;
        sel = $urandom_range(99);
        v = $urandom_range(255);
        if (pq_count > 0 && $urandom_range(3) != 0)
            v = pq_vertex[$urandom_range(pq_count - 1)];
        if (sel < load_bias) return make_op(MODE_LOAD, $urandom_range(255), random_key());
        if (sel < load_bias + 25) return make_op(MODE_EXTRACT, $urandom_range(255), $urandom);
        if (sel < load_bias + 45) return make_op(MODE_DECR, v, random_key());
        return make_op(MODE_QUERY, v, $urandom);
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Result checker and receiver stall.
    always @(posedge aclk) begin
        heap_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[39:8], m_tdata[40], m_tuser, m_tdata[49:41]};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item %h", got);
                end else begin
                    want = expected_results.pop_front();
                    case (want.status)
                        ST_OK: n_ok++;
                        ST_EMPTY: n_empty++;
                        ST_FULL: n_full++;
                        ST_ABSENT: n_absent++;
                        default: n_dup++;
                    endcase
                    if (got != want || m_tdata[55:50] != 0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: vertex %0d/%0d key %0d/%0d held %0b/%0b",
                                " st %0d/%0d cnt %0d/%0d"},
                                want.vertex, got.vertex, $signed(want.key), $signed(got.key),
                                want.held, got.held, want.status, got.status,
                                want.count, got.count);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("indexed_min_heap_queue_test: FAIL");
            $finish;
        end
    end

    initial begin
        table_row_t rows [$];
        table_row_t row;
        int phase, n, k;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = MODE_LOAD;
        m_tready = 1;
        for (int i = 0; i < 256; i++) slot_map[i] = NO_SLOT;
        pq_count = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed table: empty heap cases first, then extremes of every field.
        row.fixed = 1;
        row.item = make_op(MODE_EXTRACT, 8'h5a, 32'h0);
        row.result = '{8'h5a, 32'h0, 1'b0, ST_EMPTY, 9'd0};
        rows.push_back(row);
        row.item = make_op(MODE_DECR, 255, 32'h1);
        row.result = '{8'hff, 32'h0, 1'b0, ST_ABSENT, 9'd0};
        rows.push_back(row);
        row.item = make_op(MODE_QUERY, 0, 32'hffff_ffff);
        row.result = '{8'h00, 32'h0, 1'b0, ST_OK, 9'd0};
        rows.push_back(row);
        row.item = make_op(MODE_LOAD, 0, 32'h7fff_ffff);
        row.result = '{8'h00, 32'h7fff_ffff, 1'b1, ST_OK, 9'd1};
        rows.push_back(row);
        row.item = make_op(MODE_LOAD, 0, 32'h5);
        row.result = '{8'h00, 32'h7fff_ffff, 1'b1, ST_DUP, 9'd1};
        rows.push_back(row);
        row.item = make_op(MODE_LOAD, 255, 32'h8000_0000);
        row.result = '{8'hff, 32'h8000_0000, 1'b1, ST_OK, 9'd2};
        rows.push_back(row);
        row.fixed = 0;
        foreach (rows[i]) begin end
        begin
            op_item_t more [$];
            more.push_back(make_op(MODE_LOAD, 8'haa, 32'hffff_ffff));
            more.push_back(make_op(MODE_LOAD, 8'h55, 32'h0));
            more.push_back(make_op(MODE_LOAD, 8'h11, 32'h0));
            more.push_back(make_op(MODE_QUERY, 255, 32'h0));
            more.push_back(make_op(MODE_DECR, 0, 32'h8000_0000));
            more.push_back(make_op(MODE_DECR, 8'haa, 32'h7fff_ffff));
            more.push_back(make_op(MODE_EXTRACT, 0, 32'h0));
            more.push_back(make_op(MODE_EXTRACT, 0, 32'h0));
            more.push_back(make_op(MODE_QUERY, 0, 32'h0));
            more.push_back(make_op(MODE_EXTRACT, 0, 32'h0));
            more.push_back(make_op(MODE_EXTRACT, 0, 32'h0));
            more.push_back(make_op(MODE_EXTRACT, 0, 32'h0));
            more.push_back(make_op(MODE_EXTRACT, 8'hff, 32'hffff_ffff));
            foreach (more[i]) begin
                row.item = more[i];
                rows.push_back(row);
            end
        end
        foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].result);

        // Random phases with different idle rates; one phase fills the heap to capacity.
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 88; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 88; end
                3: begin send_idle_pct = 31; recv_stall_pct = 31; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            n = (phase == 4) ? 470 : 240;
            for (k = 0; k < n; k++) begin
                // Loading every vertex once leaves all of them held, so the heap is full.
                if (phase == 4 && k < 256)
                    send_item(make_op(MODE_LOAD, k, random_key()), 0, '0);
                else
                    send_item(random_op(phase == 1 ? 30 : 45), 0, '0);
            end
            // Sender holds off until every outstanding result has arrived.
            wait_drained();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (40) @(posedge aclk);
        $display("Sent %0d items, checked %0d results, %0d mismatches.",
            items_sent, results_seen, mismatches);
        $display("Status mix: ok %0d, empty %0d, full %0d, absent %0d, duplicate %0d.",
            n_ok, n_empty, n_full, n_absent, n_dup);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("indexed_min_heap_queue_test: PASS");
        else
            $display("indexed_min_heap_queue_test: FAIL");
        $finish;
    end
endmodule

// File: sim.f
+incdir+sv
sv/ihq_pkg.sv
sv/ihq_datapath.sv
sv/ihq_ctrl.sv
sv/indexed_min_heap_queue.sv
tb/indexed_min_heap_queue_test.sv
